// ----- rtl/core/fgs_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// fgs_pkg
// Shared constants and types for the fuzzy gain scheduler.
// ---------------------------------------------------------------------------
package fgs_pkg;

    localparam int LEVELS = 7;
    localparam int BP_W   = 9;
    localparam int LV_W   = 9;
    localparam int RULE_W = 4;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 10;
    localparam int CFG_W  = 63;
    localparam int IDX_W  = 3;
    localparam int MEM_W  = 9;   // membership 0..256
    localparam int NUM_W  = 20;  // |sum w*q| <= 512*511

    localparam logic [IDX_W-1:0] REG_ERR_BP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CHG_BP  = 3'd1;
    localparam logic [IDX_W-1:0] REG_LEVELS  = 3'd2;
    localparam logic [IDX_W-1:0] REG_RULES01 = 3'd3;
    localparam logic [IDX_W-1:0] REG_RULES23 = 3'd4;
    localparam logic [IDX_W-1:0] REG_RULES45 = 3'd5;
    localparam logic [IDX_W-1:0] REG_RULES6  = 3'd6;

    // Fuzzified input: lower level and lower membership.
    typedef struct packed {
        logic [2:0]       lvl;
        logic [MEM_W-1:0] mlow;
    } t_fuzz;

endpackage : fgs_pkg
`default_nettype wire

// ----- rtl/core/fgs_fuzz.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// fgs_fuzz
// Pipelined fuzzifier: segment search, then membership divide.
// The divide is a 9-step restoring divider split over 3 stages of 3
// quotient bits, followed by the output register (4 stages in all).
// ---------------------------------------------------------------------------
module fgs_fuzz #(
    parameter int LEVELS = fgs_pkg::LEVELS
) (
    input  wire logic                           i_clk,
    input  wire logic [fgs_pkg::CFG_W-1:0]      i_bp,
    input  wire logic [fgs_pkg::IN_W-1:0]       i_x,
    input  wire logic [3:0]                     i_en,   // per-stage advance
    output      fgs_pkg::t_fuzz                 o_fuzz
);
    localparam int BW = fgs_pkg::BP_W;
    localparam int DW = 18;  // (hi-x)*256 dividend magnitude bound < 2^18

    // stage A: segment search
    logic [2:0]    n_lvl;
    logic          n_sat;  // membership fixed, no divide
    logic [8:0]    n_fix;
    logic [DW-1:0] n_num;
    logic [10:0]   n_den;

    logic [2:0]    r_lvl [3];
    logic          r_sat [3];
    logic [8:0]    r_fix [3];
    logic [DW-1:0] r_rem [3];
    logic [10:0]   r_den [3];
    logic [8:0]    r_q   [3];

    always_comb begin
        logic signed [BW-1:0] bp [LEVELS];
        logic signed [16:0]   x;
        logic                 found;
        logic signed [16:0]   d;
        for (int i = 0; i < LEVELS; i++) bp[i] = i_bp[i*BW +: BW];
        x = {i_x[15], i_x};
        n_lvl = 3'd5; n_sat = 1'b1; n_fix = 9'd0; n_num = '0; n_den = '0;
        found = 1'b0;
        d = '0;
        if (x <= 17'(bp[0])) begin
            n_lvl = 3'd0; n_fix = 9'd256; found = 1'b1;
        end
        for (int k = 1; k < LEVELS; k++) begin
            if (!found && x <= 17'(bp[k])) begin
                found = 1'b1;
                n_lvl = 3'(k - 1);
                n_sat = 1'b0;
                d = 17'(bp[k]) - x;            // 0..510
                n_num = DW'({d[9:0], 8'd0});
                n_den = 11'(12'(bp[k]) - 12'(bp[k-1]));
            end
        end
    end

    // restoring divide, 3 quotient bits per stage, 9 bits total
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            logic [DW-1:0] rm; logic [8:0] q;
            rm = n_num; q = '0;
            for (int b = 8; b >= 6; b--) begin
                if (rm >= (DW'(n_den) << b)) begin
                    rm = rm - (DW'(n_den) << b); q[b] = 1'b1;
                end
            end
            r_lvl[0] <= n_lvl; r_sat[0] <= n_sat; r_fix[0] <= n_fix;
            r_rem[0] <= rm; r_den[0] <= n_den; r_q[0] <= q;
        end
        for (int s = 1; s < 3; s++) begin
            if (i_en[s]) begin
                logic [DW-1:0] rm; logic [8:0] q;
                rm = r_rem[s-1]; q = r_q[s-1];
                for (int b = 8 - 3*s; b >= 6 - 3*s; b--) begin
                    if (rm >= (DW'(r_den[s-1]) << b)) begin
                        rm = rm - (DW'(r_den[s-1]) << b); q[b] = 1'b1;
                    end
                end
                r_lvl[s] <= r_lvl[s-1]; r_sat[s] <= r_sat[s-1];
                r_fix[s] <= r_fix[s-1]; r_rem[s] <= rm;
                r_den[s] <= r_den[s-1]; r_q[s] <= q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            o_fuzz.lvl  <= r_lvl[2];
            o_fuzz.mlow <= r_sat[2] ? r_fix[2] : r_q[2];
        end
    end
endmodule : fgs_fuzz
`default_nettype wire

// ----- rtl/core/fgs_div.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// fgs_div
// Pipelined rounded signed divide: magnitude (2|num|+den)/(2den), 11 quotient
// bits in four stages of up to three, then sign in the output register.
// ---------------------------------------------------------------------------
module fgs_div (
    input  wire logic                      i_clk,
    input  wire logic [4:0]                i_en,
    input  wire logic                      i_neg,
    input  wire logic [fgs_pkg::NUM_W-1:0] i_mag,
    input  wire logic [9:0]                i_den,   // 1..512
    output      logic [fgs_pkg::OUT_W-1:0] o_gain
);
    localparam int NW = 22;
    localparam int QB = 11;  // quotient < 512 fits in 10 bits; 11 safe
    localparam int ST = 4;
    localparam int PER = 3;  // 11 bits over 4 stages

    typedef logic [fgs_pkg::OUT_W-1:0] t_gain;

    logic [NW-1:0] r_rem [ST];
    logic [10:0]   r_dd  [ST];
    logic [QB-1:0] r_q   [ST];
    logic          r_neg [ST];

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < ST; s++) begin
            if (i_en[s]) begin
                logic [NW-1:0] rm; logic [QB-1:0] q; logic [10:0] dd; logic ng;
                int p;
                p = (s == 0) ? 0 : s - 1;
                if (s == 0) begin
                    rm = NW'({i_mag, 1'b0}) + NW'(i_den);
                    dd = {i_den, 1'b0}; q = '0; ng = i_neg;
                end else begin
                    rm = r_rem[p]; dd = r_dd[p]; q = r_q[p]; ng = r_neg[p];
                end
                for (int b = QB - 1 - PER*s; b >= QB - PER*(s+1) && b >= 0; b--) begin
                    if (rm >= (NW'(dd) << b)) begin
                        rm = rm - (NW'(dd) << b); q[b] = 1'b1;
                    end
                end
                r_rem[s] <= rm; r_dd[s] <= dd; r_q[s] <= q; r_neg[s] <= ng;
            end
        end
        if (i_en[ST]) begin
            o_gain <= r_neg[ST-1] ? t_gain'(-r_q[ST-1]) : t_gain'(r_q[ST-1]);
        end
    end
endmodule : fgs_div
`default_nettype wire

// ----- rtl/core/fuzzy_gain_scheduler_7x7.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// fuzzy_gain_scheduler_7x7
// Fuzzy gain scheduler over a 7x7 rule table.
// ---------------------------------------------------------------------------
// Pipelined: one item per cycle while the output is not stalled. Depth
// is set by the membership divider (4 stages), rule and
// weight stages (2), the weighted sum (1), and the rounded average
// divider (5, the last of which is the output register). Output stall
// halts the whole pipe; ready follows the output register being empty
// or being taken.
module fuzzy_gain_scheduler_7x7 #(
    parameter int LEVELS = fgs_pkg::LEVELS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fgs_pkg::IDX_W-1:0]         i_cfg_idx,
    input  wire logic [fgs_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                              i_valid,
    output      logic                              o_ready,
    input  wire logic signed [fgs_pkg::IN_W-1:0]   i_error,
    input  wire logic signed [fgs_pkg::IN_W-1:0]   i_error_change,
    output      logic                              o_valid,
    input  wire logic                              i_ready,
    output      logic signed [fgs_pkg::OUT_W-1:0]  o_gain
);
    localparam int DEPTH = 12;

    logic [62:0] r_ebp, r_cbp, r_lv;
    logic [55:0] r_r01, r_r23, r_r45;
    logic [27:0] r_r6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ebp <= '0; r_cbp <= '0; r_lv <= '0;
            r_r01 <= '0; r_r23 <= '0; r_r45 <= '0; r_r6 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fgs_pkg::REG_ERR_BP:  r_ebp <= i_cfg_data;
                fgs_pkg::REG_CHG_BP:  r_cbp <= i_cfg_data;
                fgs_pkg::REG_LEVELS:  r_lv  <= i_cfg_data;
                fgs_pkg::REG_RULES01: r_r01 <= i_cfg_data[55:0];
                fgs_pkg::REG_RULES23: r_r23 <= i_cfg_data[55:0];
                fgs_pkg::REG_RULES45: r_r45 <= i_cfg_data[55:0];
                fgs_pkg::REG_RULES6:  r_r6  <= i_cfg_data[27:0];
                default: ;
            endcase
        end
    end

    // whole pipe advances together; stall when output full and not taken
    logic adv;
    logic [DEPTH-1:0] r_vld;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[DEPTH-2:0], i_valid};
    end

    fgs_pkg::t_fuzz fe, fc;
    fgs_fuzz #(.LEVELS(LEVELS)) u_fe (.i_clk, .i_bp(r_ebp), .i_x(i_error),
                                      .i_en({4{adv}}), .o_fuzz(fe));
    fgs_fuzz #(.LEVELS(LEVELS)) u_fc (.i_clk, .i_bp(r_cbp), .i_x(i_error_change),
                                      .i_en({4{adv}}), .o_fuzz(fc));

    // stage: rule lookup and weights
    logic signed [3:0] r_rl [4];
    logic [8:0]        r_w  [4];

    function automatic logic signed [3:0] rule_at(input logic [2:0] r, input logic [2:0] c,
                                                  input logic [195:0] tbl);
        logic signed [3:0] v;
        v = 4'sd0;
        if (r < 3'd7 && c < 3'd7) begin
            v = tbl[4*(32'(r)*7 + 32'(c)) +: 4];
            if (v > 4'sd6) v = 4'sd6;
            if (v < -4'sd6) v = -4'sd6;
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            logic [195:0] tbl;
            logic [8:0] me0, me1, mc0, mc1;
            tbl = {r_r6, r_r45, r_r23, r_r01};
            me0 = fe.mlow; me1 = 9'd256 - fe.mlow;
            mc0 = fc.mlow; mc1 = 9'd256 - fc.mlow;
            r_rl[0] <= rule_at(fe.lvl, fc.lvl, tbl);
            r_rl[1] <= rule_at(fe.lvl + 3'd1, fc.lvl, tbl);
            r_rl[2] <= rule_at(fe.lvl, fc.lvl + 3'd1, tbl);
            r_rl[3] <= rule_at(fe.lvl + 3'd1, fc.lvl + 3'd1, tbl);
            r_w[0] <= (me0 < mc0) ? me0 : mc0;
            r_w[1] <= (me1 < mc0) ? me1 : mc0;
            r_w[2] <= (me0 < mc1) ? me0 : mc1;
            r_w[3] <= (me1 < mc1) ? me1 : mc1;
        end
    end

    // stage: shared consequent pruning and level values
    logic [8:0]        r_w2 [4];
    logic signed [9:0] r_q  [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            logic [8:0] w [4];
            logic [3:0] mag;
            logic [8:0] lv;
            for (int a = 0; a < 4; a++) w[a] = r_w[a];
            for (int a = 0; a < 3; a++)
                for (int b = a + 1; b < 4; b++)
                    if (r_rl[a] == r_rl[b]) begin
                        if (w[a] > w[b]) w[b] = 9'd0;
                        else w[a] = 9'd0;
                    end
            for (int a = 0; a < 4; a++) begin
                mag = r_rl[a][3] ? 4'(-r_rl[a]) : 4'(r_rl[a]);
                lv  = r_lv[9*32'(mag[2:0]) +: 9];
                r_q[a]  <= r_rl[a][3] ? -$signed({1'b0, lv}) : $signed({1'b0, lv});
                r_w2[a] <= w[a];
            end
        end
    end

    // stage: weighted sum
    logic                      r_neg;
    logic [fgs_pkg::NUM_W-1:0] r_mag;
    logic [9:0]                r_den;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            logic signed [21:0] num;
            logic [10:0] den;
            num = '0; den = '0;
            for (int a = 0; a < 4; a++) begin
                num = num + 22'($signed({1'b0, r_w2[a]})) * 22'(r_q[a]);
                den = den + 11'(r_w2[a]);
            end
            r_neg <= num[21];
            r_mag <= num[21] ? fgs_pkg::NUM_W'(-num) : fgs_pkg::NUM_W'(num);
            r_den <= den[9:0];
        end
    end

    logic [fgs_pkg::OUT_W-1:0] gain;
    fgs_div u_div (.i_clk, .i_en({5{adv}}), .i_neg(r_neg), .i_mag(r_mag), .i_den(r_den),
                   .o_gain(gain));
    assign o_gain = gain;
endmodule : fuzzy_gain_scheduler_7x7
`default_nettype wire

// ----- rtl/core/fgs_checker.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// fgs_checker
// Port-level checks for the fuzzy gain scheduler.
// ---------------------------------------------------------------------------
module fgs_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic       o_ready,
    input wire logic [9:0] o_gain
);
    // result stays put while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_gain)) else $error("gain moved");
    // gain stays within Q1.8 range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_gain != 10'h200) else $error("gain out of range");
    // input side never blocked while output is free
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("ready low with empty output");
endmodule : fgs_checker

bind fuzzy_gain_scheduler_7x7 fgs_checker u_chk (.i_clk, .i_rst_n, .o_valid, .i_ready,
                                                 .o_ready, .o_gain);
`default_nettype wire
